/* src/icle_pkg.sv */
// Shared types and constants for the indexed byte list engine.
package icle_pkg;

    localparam int OP_W          = 4;
    localparam int VALUE_W       = 8;
    localparam int POS_FIELD_W   = 5;
    localparam int STATUS_W      = 3;
    localparam int COUNT_FIELD_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_INSERT_AT  = 4'd2,
        OP_POP_BACK   = 4'd3,
        OP_POP_FRONT  = 4'd4,
        OP_REMOVE_AT  = 4'd5,
        OP_SWAP       = 4'd6,
        OP_CLEAR      = 4'd7,
        OP_REVERSE    = 4'd8,
        OP_READ       = 4'd9
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_RANGE = 3'd3,
        ST_ORDER = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_SWAP   = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [VALUE_W-1:0] value;
    } cell_cmd_t;

endpackage

/* src/icle_cell.sv */
// One storage cell of the list: holds a byte, shifts with its neighbors.
module icle_cell import icle_pkg::*; #(
    parameter int PW    = 5,
    parameter int INDEX = 0
) (
    input  logic               aclk,
    input  cell_cmd_t          cmd,
    input  logic [PW-1:0]      pos_a,
    input  logic [PW-1:0]      pos_b,
    input  logic [VALUE_W-1:0] left_in,
    input  logic [VALUE_W-1:0] right_in,
    input  logic [VALUE_W-1:0] swap_a_in,
    input  logic [VALUE_W-1:0] swap_b_in,
    output logic [VALUE_W-1:0] data_out,
    output logic [VALUE_W-1:0] sel_a_out,
    output logic [VALUE_W-1:0] sel_b_out
);

    localparam logic [PW-1:0] MY_IDX = PW'(INDEX);

    logic [VALUE_W-1:0] data_reg, data_next;
    logic               at_a, at_b, above_a;

    assign at_a    = (pos_a == MY_IDX);
    assign at_b    = (pos_b == MY_IDX);
    assign above_a = (MY_IDX > pos_a);

    always_comb begin
        data_next = data_reg;
        case (cmd.op)
            CELL_INSERT: begin
                if (at_a) begin
                    data_next = cmd.value;
                end else if (above_a) begin
                    data_next = left_in;
                end
            end
            CELL_REMOVE: begin
                if (at_a || above_a) begin
                    data_next = right_in;
                end
            end
            CELL_SWAP: begin
                if (at_a) begin
                    data_next = swap_b_in;
                end else if (at_b) begin
                    data_next = swap_a_in;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out  = data_reg;
    assign sel_a_out = at_a ? data_reg : '0;
    assign sel_b_out = at_b ? data_reg : '0;

endmodule

/* src/icle_ctrl.sv */
// Command decode, element count and orientation flag of the list.
module icle_ctrl import icle_pkg::*; #(
    parameter int CAPACITY = 16,
    parameter int PW       = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     fire,
    input  op_t                      op,
    input  logic [VALUE_W-1:0]       value,
    input  logic [POS_FIELD_W-1:0]   position,
    input  logic [POS_FIELD_W-1:0]   second_position,
    output cell_cmd_t                cmd,
    output logic [PW-1:0]            pos_a,
    output logic [PW-1:0]            pos_b,
    output status_t                  status,
    output logic [COUNT_FIELD_W-1:0] count_out
);

    localparam int            CW    = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] CAP_X = PW'(CAPACITY);

    logic [CW-1:0] count_reg, count_next;
    logic          rev_reg, rev_next;
    logic [PW-1:0] cnt_x, p1x, p2x, lp_ins, lp_rem;
    logic [PW-1:0] ins_phys, rem_phys, cnt_next_x;
    logic          full, empty;
    cell_op_t      cop;

    assign cnt_x = PW'(count_reg);
    assign p1x   = PW'(position);
    assign p2x   = PW'(second_position);
    assign full  = (cnt_x == CAP_X);
    assign empty = (count_reg == '0);

    // logical position -> physical cell; rev_reg means the cells hold the list back to front
    assign lp_ins   = (op == OP_PUSH_BACK) ? cnt_x : ((op == OP_PUSH_FRONT) ? '0 : p1x);
    assign lp_rem   = (op == OP_POP_BACK) ? (cnt_x - PW'(1)) :
                      ((op == OP_POP_FRONT) ? '0 : p1x);
    assign ins_phys = rev_reg ? (cnt_x - lp_ins) : lp_ins;
    assign rem_phys = rev_reg ? (cnt_x - PW'(1) - lp_rem) : lp_rem;
    assign pos_b    = rev_reg ? (cnt_x - PW'(1) - p2x) : p2x;

    always_comb begin
        status     = ST_OK;
        cop        = CELL_HOLD;
        count_next = count_reg;
        rev_next   = rev_reg;
        pos_a      = rem_phys;
        unique case (op) inside
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                pos_a = ins_phys;
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cop        = CELL_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_INSERT_AT: begin
                pos_a = ins_phys;
                if (full) begin
                    status = ST_FULL;
                end else if (p1x > cnt_x) begin
                    status = ST_RANGE;
                end else begin
                    cop        = CELL_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    cop        = CELL_REMOVE;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_REMOVE_AT: begin
                if (p1x >= cnt_x) begin
                    status = ST_RANGE;
                end else begin
                    cop        = CELL_REMOVE;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_SWAP: begin
                if ((p1x >= cnt_x) || (p2x >= cnt_x)) begin
                    status = ST_RANGE;
                end else if (p1x >= p2x) begin
                    status = ST_ORDER;
                end else begin
                    cop = CELL_SWAP;
                end
            end
            OP_CLEAR: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    count_next = '0;
                    rev_next   = 1'b0;
                end
            end
            OP_REVERSE: begin
                rev_next = !rev_reg;
            end
            OP_READ: begin
                if (p1x >= cnt_x) begin
                    status = ST_RANGE;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign cmd.op     = fire ? cop : CELL_HOLD;
    assign cmd.value  = value;
    assign cnt_next_x = PW'(count_next);
    assign count_out  = cnt_next_x[COUNT_FIELD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end else if (fire) begin
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_x <= CAP_X)
        else $error("element count above capacity");

    a_full_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (status == ST_FULL) |=> $stable(count_reg))
        else $error("rejected push changed the count");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && ((op == OP_PUSH_BACK) || (op == OP_PUSH_FRONT)) && (status == ST_OK)
        |=> count_reg == ($past(count_reg) + CW'(1)))
        else $error("accepted push did not add one element");

    a_rev_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (op == OP_REVERSE) |=> rev_reg != $past(rev_reg))
        else $error("reverse did not flip orientation");
`endif

endmodule

/* src/indexed_char_list_engine.sv */
// Top level of the indexed byte list engine: cell chain, control and result register.
//
//  channel  | direction | payload (low bit up)
//  ---------+-----------+------------------------------------------------------------
//  s_*      | in        | tuser: operation[3:0]; tdata: element_value, position,
//           |           |        second_position, zero pad to 24 bits
//  m_*      | out       | tdata: status[2:0], element_count[7:3], read_value[15:8]
//
// Commands: each taken command acts on the cell row, which updates in parallel
//   (shift up on insert, shift down on remove, two-cell exchange on swap).
// Reverse flips an orientation flag in the control block; positions are mapped
//   through it, so no data moves.
// Reset: aresetn clears the count, the flag and the result valid; cell contents
//   are left as they are, since only cells below the count are ever read.
// Stalls: s_tready drops only while a result is held and m_tready is low; with
//   m_tready high a command is taken every cycle.
module indexed_char_list_engine import icle_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // element_value[7:0], position[12:8], second_position[17:13]
    input  logic [3:0]  s_tuser,   // operation[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[2:0], element_count[7:3], read_value[15:8]
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_FIELD_W) ? CW : POS_FIELD_W;

    // field positions in s_tdata
    localparam int VAL_LO = 0;
    localparam int P1_LO  = VAL_LO + VALUE_W;
    localparam int P2_LO  = P1_LO + POS_FIELD_W;

    logic                     fire;
    op_t                      s_op;
    logic [VALUE_W-1:0]       s_value;
    logic [POS_FIELD_W-1:0]   s_pos1, s_pos2;
    cell_cmd_t                cmd;
    logic [PW-1:0]            pos_a, pos_b;
    status_t                  status;
    logic [COUNT_FIELD_W-1:0] count_out;

    logic [VALUE_W-1:0] cell_data  [CAPACITY];
    logic [VALUE_W-1:0] cell_sel_a [CAPACITY];
    logic [VALUE_W-1:0] cell_sel_b [CAPACITY];
    logic [VALUE_W-1:0] gath_a, gath_b, read_value;

    logic        m_valid_reg;
    logic [15:0] m_data_reg;

    assign s_op    = op_t'(s_tuser[OP_W-1:0]);
    assign s_value = s_tdata[VAL_LO +: VALUE_W];
    assign s_pos1  = s_tdata[P1_LO +: POS_FIELD_W];
    assign s_pos2  = s_tdata[P2_LO +: POS_FIELD_W];

    // output register parts the two sides; a held result blocks only when not taken
    assign s_tready = !m_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    icle_ctrl #(
        .CAPACITY (CAPACITY),
        .PW       (PW)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .fire            (fire),
        .op              (s_op),
        .value           (s_value),
        .position        (s_pos1),
        .second_position (s_pos2),
        .cmd             (cmd),
        .pos_a           (pos_a),
        .pos_b           (pos_b),
        .status          (status),
        .count_out       (count_out)
    );

    // row of cells; each takes its left or right neighbor on a shift
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_W-1:0] left_d, right_d;

        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        icle_cell #(
            .PW    (PW),
            .INDEX (i)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .pos_a     (pos_a),
            .pos_b     (pos_b),
            .left_in   (left_d),
            .right_in  (right_d),
            .swap_a_in (gath_a),
            .swap_b_in (gath_b),
            .data_out  (cell_data[i]),
            .sel_a_out (cell_sel_a[i]),
            .sel_b_out (cell_sel_b[i])
        );
    end

    // at most one cell drives each select, so an OR gathers it
    always_comb begin
        gath_a = '0;
        gath_b = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            gath_a = gath_a | cell_sel_a[i];
            gath_b = gath_b | cell_sel_b[i];
        end
    end

    assign read_value = ((s_op == OP_READ) && (status == ST_OK)) ? gath_a : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= {read_value, count_out, status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* bench/indexed_char_list_engine_tb.sv */
// Self-checking stream testbench for the indexed byte list engine.
`timescale 1ns / 1ps

module indexed_char_list_engine_tb import icle_pkg::*; ();

    localparam int CAPACITY        = 16;
    localparam int CLK_HALF_NS     = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 10;      // spare edges at the end before the summary
    localparam int LONG_HOLD       = 150;     // receiver back-pressure stretch, in cycles
    localparam int ITEMS_PER_PHASE = 328;     // four idling phases, about 1350 commands in all

    // Codes 10..15 are not operations; the block must treat them as no-ops.
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_READ + 4'd1;
    localparam logic [OP_W-1:0] OP_CODE_MAX     = 4'hF;

    // One command as it goes onto the input channel.
    typedef struct {
        logic [OP_W-1:0]        op;
        logic [VALUE_W-1:0]     value;
        logic [POS_FIELD_W-1:0] pos;
        logic [POS_FIELD_W-1:0] pos2;
    } list_cmd_t;

    // One response word from the result channel.
    typedef struct {
        status_t                  status;
        logic [COUNT_FIELD_W-1:0] count;
        logic [VALUE_W-1:0]       rd;
    } list_resp_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // element_value[7:0], position[12:8], second_position[17:13]
    logic [3:0]  s_tuser  = '0;   // operation[3:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // status[2:0], element_count[7:3], read_value[15:8]

    indexed_char_list_engine #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #(CLK_HALF_NS) aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------
    list_cmd_t  pending_cmds[$];     // commands not yet transferred, front is on the bus
    list_resp_t expected_resps[$];   // predicted responses, oldest first

    logic [VALUE_W-1:0] list_bytes[CAPACITY];  // predicted list contents
    int                 list_len = 0;          // predicted element count

    bit  cmd_taken      = 1'b0;  // set at the edge a command transfer happens
    int  sender_idle_pct = 0;
    int  sink_stall_pct  = 0;
    bit  hold_req        = 1'b0; // asks the receiver for one long hold-off
    int  hold_left       = 0;

    int  cycle_count   = 0;
    int  mismatches    = 0;
    int  cmds_accepted = 0;
    int  resps_checked = 0;
    int  status_seen[ST_ORDER+1];

    // ------------------------------------------------------------------
    // List predictor
    // ------------------------------------------------------------------
    // Open a slot at 'at', moving later elements up by one.
    function automatic void list_open_slot(int at, logic [VALUE_W-1:0] v);
        int i;
        for (i = list_len; i > at; i--)
            list_bytes[i] = list_bytes[i-1];
        list_bytes[at] = v;
        list_len++;
    endfunction

    // Close the slot at 'at', moving later elements down by one.
    function automatic void list_close_slot(int at);
        int i;
        for (i = at; i + 1 < list_len; i++)
            list_bytes[i] = list_bytes[i+1];
        list_len--;
    endfunction

    // Apply one command to the predicted list and return the response it must give.
    function automatic list_resp_t apply_list_cmd(list_cmd_t c);
        list_resp_t         r;
        logic [VALUE_W-1:0] t;
        int                 p1;
        int                 p2;
        int                 lo;
        int                 hi;
        r.status = ST_OK;
        r.rd     = '0;
        p1       = c.pos;
        p2       = c.pos2;
        case (c.op)
            OP_PUSH_BACK: begin
                if (list_len >= CAPACITY) r.status = ST_FULL;
                else list_open_slot(list_len, c.value);
            end
            OP_PUSH_FRONT: begin
                if (list_len >= CAPACITY) r.status = ST_FULL;
                else list_open_slot(0, c.value);
            end
            OP_INSERT_AT: begin
                // full wins over a bad index; index == count appends
                if (list_len >= CAPACITY) r.status = ST_FULL;
                else if (p1 > list_len) r.status = ST_RANGE;
                else list_open_slot(p1, c.value);
            end
            OP_POP_BACK: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_len--;
            end
            OP_POP_FRONT: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_close_slot(0);
            end
            OP_REMOVE_AT: begin
                if (p1 >= list_len) r.status = ST_RANGE;
                else list_close_slot(p1);
            end
            OP_SWAP: begin
                // range check comes before the order check
                if (p1 >= list_len || p2 >= list_len) r.status = ST_RANGE;
                else if (p1 >= p2) r.status = ST_ORDER;
                else begin
                    t              = list_bytes[p1];
                    list_bytes[p1] = list_bytes[p2];
                    list_bytes[p2] = t;
                end
            end
            OP_CLEAR: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_len = 0;
            end
            OP_REVERSE: begin
                lo = 0;
                hi = list_len - 1;
                while (lo < hi) begin
                    t              = list_bytes[lo];
                    list_bytes[lo] = list_bytes[hi];
                    list_bytes[hi] = t;
                    lo++;
                    hi--;
                end
            end
            OP_READ: begin
                if (p1 >= list_len) r.status = ST_RANGE;
                else r.rd = list_bytes[p1];
            end
            default: ;  // unused code: no change, status ok
        endcase
        r.count = list_len[COUNT_FIELD_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents pending commands at the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || cmd_taken) begin
            // bus is free (nothing offered, or last offer just transferred)
            cmd_taken = 1'b0;
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_cmds[0].op;
                s_tdata  <= {6'b0, pending_cmds[0].pos2, pending_cmds[0].pos,
                             pending_cmds[0].value};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each command transfer, checks each result transfer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : mon_blk
        list_resp_t want;
        list_resp_t got;
        cycle_count++;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_resps.insert(expected_resps.size(), apply_list_cmd(pending_cmds[0]));
                void'(pending_cmds.pop_front());
                cmd_taken = 1'b1;
                cmds_accepted++;
            end
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tdata[2:0]);
                got.count  = m_tdata[7:3];
                got.rd     = m_tdata[15:8];
                if (expected_resps.size() == 0) begin
                    $error("unexpected result transfer: tdata=%h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_resps.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.count !== want.count) begin
                        $error("element_count: expected %0d, got %0d", want.count, got.count);
                        mismatches++;
                    end
                    if (got.rd !== want.rd) begin
                        $error("read_value: expected %h, got %h", want.rd, got.rd);
                        mismatches++;
                    end
                    if (want.status <= ST_ORDER) status_seen[want.status]++;
                    resps_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_cmd(logic [OP_W-1:0] op, logic [VALUE_W-1:0] v,
                             logic [POS_FIELD_W-1:0] p, logic [POS_FIELD_W-1:0] p2);
        list_cmd_t c;
        c.op    = op;
        c.value = v;
        c.pos   = p;
        c.pos2  = p2;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // Sender stays quiet until every command is through and every response is back.
    task automatic wait_all_done();
        while (pending_cmds.size() > 0 || expected_resps.size() > 0)
            @(posedge aclk);
    endtask

    // Operation mix: a filling run favors adds, a draining run favors removals.
    function automatic logic [OP_W-1:0] pick_op(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 25) return OP_PUSH_BACK;
            if (r < 45) return OP_PUSH_FRONT;
            if (r < 65) return OP_INSERT_AT;
            if (r < 70) return OP_POP_BACK;
            if (r < 73) return OP_POP_FRONT;
            if (r < 76) return OP_REMOVE_AT;
            if (r < 84) return OP_SWAP;
            if (r < 87) return OP_REVERSE;
            if (r < 96) return OP_READ;
            if (r < 97) return OP_CLEAR;
        end else begin
            if (r < 8)  return OP_PUSH_BACK;
            if (r < 12) return OP_PUSH_FRONT;
            if (r < 18) return OP_INSERT_AT;
            if (r < 35) return OP_POP_BACK;
            if (r < 50) return OP_POP_FRONT;
            if (r < 65) return OP_REMOVE_AT;
            if (r < 75) return OP_SWAP;
            if (r < 79) return OP_REVERSE;
            if (r < 93) return OP_READ;
            if (r < 96) return OP_CLEAR;
        end
        return OP_W'($urandom_range(OP_FIRST_UNUSED, OP_CODE_MAX));
    endfunction

    // Mostly in-range indexes, sometimes anything the 5-bit field can carry.
    function automatic logic [POS_FIELD_W-1:0] pick_pos();
        if ($urandom_range(0, 99) < 85) return POS_FIELD_W'($urandom_range(0, CAPACITY));
        return POS_FIELD_W'($urandom_range(0, 31));
    endfunction

    task automatic queue_random(int n);
        int        i;
        int        run_left;
        bit        filling;
        list_cmd_t c;
        run_left = 0;
        filling  = 1'b1;
        for (i = 0; i < n; i++) begin
            if (run_left == 0) begin
                filling  = ($urandom_range(0, 1) == 1);
                run_left = $urandom_range(10, 40);
            end
            run_left--;
            c.op    = pick_op(filling);
            c.value = VALUE_W'($urandom_range(0, 255));
            c.pos   = pick_pos();
            c.pos2  = pick_pos();
            // keep most swaps well ordered so they get past the order check
            if (c.op == OP_SWAP && $urandom_range(0, 99) < 70)
                c.pos2 = POS_FIELD_W'(c.pos + $urandom_range(1, 4));
            pending_cmds.insert(pending_cmds.size(), c);
        end
    endtask

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("cycle limit reached with %0d responses outstanding", expected_resps.size());
        $display("indexed_char_list_engine_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int ph;
        int i;
        for (i = 0; i <= ST_ORDER; i++) status_seen[i] = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-list rejections and an empty reverse
        queue_cmd(OP_POP_BACK,  8'h00, 5'd0, 5'd0);
        queue_cmd(OP_POP_FRONT, 8'h00, 5'd0, 5'd0);
        queue_cmd(OP_CLEAR,     8'h00, 5'd0, 5'd0);
        queue_cmd(OP_REMOVE_AT, 8'h00, 5'd0, 5'd0);
        queue_cmd(OP_READ,      8'h00, 5'd0, 5'd0);
        queue_cmd(OP_SWAP,      8'h00, 5'd0, 5'd1);
        queue_cmd(OP_REVERSE,   8'h00, 5'd0, 5'd0);
        queue_cmd(OP_INSERT_AT, 8'h11, 5'd1, 5'd0);   // index past count
        // short list: one-element reverse, append via insert, swap order checks
        queue_cmd(OP_INSERT_AT, 8'h00, 5'd0, 5'd0);
        queue_cmd(OP_REVERSE,   8'h00, 5'd0, 5'd0);
        queue_cmd(OP_PUSH_FRONT, 8'hFF, 5'd0, 5'd0);
        queue_cmd(OP_INSERT_AT, 8'h5A, 5'd2, 5'd0);   // index == count appends
        queue_cmd(OP_SWAP,      8'h00, 5'd1, 5'd1);
        queue_cmd(OP_SWAP,      8'h00, 5'd2, 5'd0);
        queue_cmd(OP_SWAP,      8'h00, 5'd0, 5'd2);
        queue_cmd(OP_READ,      8'h00, 5'd31, 5'd31);
        queue_cmd(OP_READ,      8'h00, 5'd2, 5'd0);
        queue_cmd(OP_REMOVE_AT, 8'h00, 5'd1, 5'd0);
        queue_cmd(OP_CODE_MAX,  8'hFF, 5'd31, 5'd31); // unused code, all-ones payload
        // fill to capacity, then the full cases
        for (i = 0; i < CAPACITY - 2; i++)
            queue_cmd(OP_PUSH_BACK, 8'(8'h30 + i), 5'd0, 5'd0);
        queue_cmd(OP_PUSH_BACK,  8'hEE, 5'd0, 5'd0);
        queue_cmd(OP_PUSH_FRONT, 8'hEE, 5'd0, 5'd0);
        queue_cmd(OP_INSERT_AT,  8'hEE, 5'd31, 5'd0); // full beats bad index
        queue_cmd(OP_REVERSE,    8'h00, 5'd0, 5'd0);
        queue_cmd(OP_READ,       8'h00, 5'(CAPACITY - 1), 5'd0);
        queue_cmd(OP_POP_FRONT,  8'h00, 5'd0, 5'd0);
        queue_cmd(OP_CLEAR,      8'h00, 5'd0, 5'd0);
        wait_all_done();

        // Random phases: none, sender gaps, receiver stalls, both.
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 45; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 45; end
                default: begin sender_idle_pct = 26; sink_stall_pct = 26; end
            endcase
            // long back-pressure while the sender keeps offering
            if (ph == 0) hold_req = 1'b1;
            queue_random(ITEMS_PER_PHASE);
            wait_all_done();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d commands and %0d checked responses over four idling phases",
                 cmds_accepted, resps_checked);
        $display("rejections seen: full %0d, empty %0d, range %0d, swap order %0d",
                 status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_RANGE], status_seen[ST_ORDER]);
        if (mismatches == 0 && expected_resps.size() == 0) begin
            $display("indexed_char_list_engine_tb: clean");
        end else begin
            $display("indexed_char_list_engine_tb: errors");
        end
        $finish;
    end

endmodule

/* files.f */
src/icle_pkg.sv
src/icle_cell.sv
src/icle_ctrl.sv
src/indexed_char_list_engine.sv
bench/indexed_char_list_engine_tb.sv
